// ===== hw/rtl/rso_pkg.sv =====
// Shared types, constants and tables of the random shape oscillator.
package rso_pkg;

	// Default phase steps per 16-bit phase unit
	localparam int STEP_SIZE_DEF = 8192;

	// Configuration register indexes and reset values
	localparam logic CFG_STEP_PER_HZ = 1'b0;
	localparam logic CFG_NOISE_SEED = 1'b1;
	localparam logic [23:0] STEP_PER_HZ_RST = 24'd194784;
	localparam logic [31:0] NOISE_SEED_RST = 32'd404933;

	// Fixed-point constants
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [31:0] LN2_Q30 = 32'd744261118;
	localparam logic [31:0] LCG_MUL = 32'd435898247;
	localparam logic [31:0] LCG_ADD = 32'd382842987;
	localparam logic [31:0] COS_SEED = 32'd296;

	// Loop bounds
	localparam logic [3:0] COS_LAST = 4'd4;
	localparam logic [3:0] SQ_LAST = 4'd15;
	localparam logic [3:0] EXP_FIRST = 4'd10;
	localparam logic [3:0] EXP_LAST = 4'd1;

	// Controller states
	typedef enum logic [4:0] {
		S_IDLE, S_DIV, S_LCG, S_P16, S_X, S_XX, S_YW, S_CMUL, S_CACC, S_CD,
		S_CC, S_H, S_B1, S_B2, S_B3, S_PW0, S_SQ, S_SQW, S_LG, S_T, S_TW,
		S_Z, S_E1, S_E2, S_E3, S_PWR, S_O1, S_O2, S_PH
	} st_t;

	// Datapath operations
	typedef enum logic [4:0] {
		OP_IDLE, OP_TAKE, OP_DIV, OP_LCG, OP_P16, OP_X, OP_XX, OP_YW, OP_CMUL,
		OP_CACC, OP_CD, OP_CC, OP_H, OP_B1, OP_B2, OP_B3, OP_PW0, OP_SQ,
		OP_SQW, OP_LG, OP_T, OP_TW, OP_Z, OP_E1, OP_E2, OP_E3, OP_PWR, OP_O1,
		OP_O2, OP_PH
	} op_t;

	typedef struct packed {
		op_t op;
		logic [3:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic blend_zero;
		logic ip_big;
		logic out_stall;
	} dp_stat_t;

	// Taylor coefficients of the cosine, Q.30, outermost last
	function automatic logic [31:0] cos_coef(input logic [3:0] idx);
		logic [31:0] r;
		case (idx)
			4'd0: r = 32'd26631;
			4'd1: r = 32'd1491308;
			4'd2: r = 32'd44739243;
			4'd3: r = 32'd536870912;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// floor(2^32 / i), one below for i = 1
	function automatic logic [31:0] div_recip(input logic [3:0] idx);
		logic [31:0] r;
		case (idx)
			4'd1: r = 32'hFFFF_FFFF;
			4'd2: r = 32'd2147483648;
			4'd3: r = 32'd1431655765;
			4'd4: r = 32'd1073741824;
			4'd5: r = 32'd858993459;
			4'd6: r = 32'd715827882;
			4'd7: r = 32'd613566756;
			4'd8: r = 32'd536870912;
			4'd9: r = 32'd477218588;
			4'd10: r = 32'd429496729;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/random_shape_oscillator.sv =====
// Top level of the random shape oscillator: controller plus datapath.
// A sample request runs through the whole state sequence before the next request can be
// accepted (a shorter one when the blended shape is zero or the power underflows); a
// phase-set request is applied from the idle state. The sequence is set by the single
// shared 32x32 multiplier, whose registered product feeds each dependent step: phase
// scaling, the cosine polynomial, sixteen squarings for log2 and a ten-term exp2 series
// with small divides. The result sits in an output register, so a new request is taken
// while it waits; that request then holds just before its output step until the waiting
// result is taken. Configuration writes take effect at once; writing noise_seed also
// reloads the random generator.
module random_shape_oscillator #(
	parameter int STEP_SIZE = rso_pkg::STEP_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [23:0] frequency,
	input  logic [16:0]        crossfade,
	input  logic [15:0]        exponent,
	input  logic [15:0]        phase_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] sample
);

	rso_pkg::dp_cmd_t  dp_cmd;
	rso_pkg::dp_stat_t dp_stat;

	// Sequencer
	rso_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	// Arithmetic and state
	rso_datapath #(
		.STEP_SIZE (STEP_SIZE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.stat        (dp_stat),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.frequency   (frequency),
		.crossfade   (crossfade),
		.exponent    (exponent),
		.phase_value (phase_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample      (sample)
	);

endmodule

// ===== hw/rtl/rso_ctrl.sv =====
// Sequencing state machine of the random shape oscillator.
module rso_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	input  rso_pkg::dp_stat_t stat,
	output rso_pkg::dp_cmd_t  dp_cmd
);

	rso_pkg::st_t state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	// State and loop counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rso_pkg::S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		case (state_q)
			rso_pkg::S_IDLE: if (in_valid && !in_cmd) state_d = rso_pkg::S_DIV;
			rso_pkg::S_DIV: state_d = rso_pkg::S_LCG;
			rso_pkg::S_LCG: state_d = rso_pkg::S_P16;
			rso_pkg::S_P16: state_d = rso_pkg::S_X;
			rso_pkg::S_X: state_d = rso_pkg::S_XX;
			rso_pkg::S_XX: state_d = rso_pkg::S_YW;
			rso_pkg::S_YW: begin
				state_d = rso_pkg::S_CMUL;
				cnt_d = '0;
			end
			rso_pkg::S_CMUL: begin
				state_d = (cnt_q == rso_pkg::COS_LAST) ? rso_pkg::S_CD : rso_pkg::S_CACC;
			end
			rso_pkg::S_CACC: begin
				state_d = rso_pkg::S_CMUL;
				cnt_d = cnt_q + 4'd1;
			end
			rso_pkg::S_CD: state_d = rso_pkg::S_CC;
			rso_pkg::S_CC: state_d = rso_pkg::S_H;
			rso_pkg::S_H: state_d = rso_pkg::S_B1;
			rso_pkg::S_B1: state_d = rso_pkg::S_B2;
			rso_pkg::S_B2: state_d = rso_pkg::S_B3;
			rso_pkg::S_B3: state_d = rso_pkg::S_PW0;
			rso_pkg::S_PW0: begin
				state_d = stat.blend_zero ? rso_pkg::S_O1 : rso_pkg::S_SQ;
				cnt_d = '0;
			end
			rso_pkg::S_SQ: state_d = rso_pkg::S_SQW;
			rso_pkg::S_SQW: begin
				if (cnt_q == rso_pkg::SQ_LAST) begin
					state_d = rso_pkg::S_LG;
				end else begin
					state_d = rso_pkg::S_SQ;
					cnt_d = cnt_q + 4'd1;
				end
			end
			rso_pkg::S_LG: state_d = rso_pkg::S_T;
			rso_pkg::S_T: state_d = rso_pkg::S_TW;
			rso_pkg::S_TW: state_d = stat.ip_big ? rso_pkg::S_O1 : rso_pkg::S_Z;
			rso_pkg::S_Z: begin
				state_d = rso_pkg::S_E1;
				cnt_d = rso_pkg::EXP_FIRST;
			end
			rso_pkg::S_E1: state_d = rso_pkg::S_E2;
			rso_pkg::S_E2: state_d = rso_pkg::S_E3;
			rso_pkg::S_E3: begin
				if (cnt_q == rso_pkg::EXP_LAST) begin
					state_d = rso_pkg::S_PWR;
				end else begin
					state_d = rso_pkg::S_E1;
					cnt_d = cnt_q - 4'd1;
				end
			end
			rso_pkg::S_PWR: state_d = rso_pkg::S_O1;
			// hold the output product here until the output register is free
			rso_pkg::S_O1: if (!stat.out_stall) state_d = rso_pkg::S_O2;
			rso_pkg::S_O2: state_d = rso_pkg::S_PH;
			rso_pkg::S_PH: state_d = rso_pkg::S_IDLE;
			default: state_d = rso_pkg::S_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		in_ready = (state_q == rso_pkg::S_IDLE);
		dp_cmd.idx = cnt_q;
		case (state_q)
			rso_pkg::S_IDLE: dp_cmd.op = in_valid ? rso_pkg::OP_TAKE : rso_pkg::OP_IDLE;
			rso_pkg::S_DIV: dp_cmd.op = rso_pkg::OP_DIV;
			rso_pkg::S_LCG: dp_cmd.op = rso_pkg::OP_LCG;
			rso_pkg::S_P16: dp_cmd.op = rso_pkg::OP_P16;
			rso_pkg::S_X: dp_cmd.op = rso_pkg::OP_X;
			rso_pkg::S_XX: dp_cmd.op = rso_pkg::OP_XX;
			rso_pkg::S_YW: dp_cmd.op = rso_pkg::OP_YW;
			rso_pkg::S_CMUL: dp_cmd.op = rso_pkg::OP_CMUL;
			rso_pkg::S_CACC: dp_cmd.op = rso_pkg::OP_CACC;
			rso_pkg::S_CD: dp_cmd.op = rso_pkg::OP_CD;
			rso_pkg::S_CC: dp_cmd.op = rso_pkg::OP_CC;
			rso_pkg::S_H: dp_cmd.op = rso_pkg::OP_H;
			rso_pkg::S_B1: dp_cmd.op = rso_pkg::OP_B1;
			rso_pkg::S_B2: dp_cmd.op = rso_pkg::OP_B2;
			rso_pkg::S_B3: dp_cmd.op = rso_pkg::OP_B3;
			rso_pkg::S_PW0: dp_cmd.op = rso_pkg::OP_PW0;
			rso_pkg::S_SQ: dp_cmd.op = rso_pkg::OP_SQ;
			rso_pkg::S_SQW: dp_cmd.op = rso_pkg::OP_SQW;
			rso_pkg::S_LG: dp_cmd.op = rso_pkg::OP_LG;
			rso_pkg::S_T: dp_cmd.op = rso_pkg::OP_T;
			rso_pkg::S_TW: dp_cmd.op = rso_pkg::OP_TW;
			rso_pkg::S_Z: dp_cmd.op = rso_pkg::OP_Z;
			rso_pkg::S_E1: dp_cmd.op = rso_pkg::OP_E1;
			rso_pkg::S_E2: dp_cmd.op = rso_pkg::OP_E2;
			rso_pkg::S_E3: dp_cmd.op = rso_pkg::OP_E3;
			rso_pkg::S_PWR: dp_cmd.op = rso_pkg::OP_PWR;
			rso_pkg::S_O1: dp_cmd.op = rso_pkg::OP_O1;
			rso_pkg::S_O2: dp_cmd.op = rso_pkg::OP_O2;
			rso_pkg::S_PH: dp_cmd.op = rso_pkg::OP_PH;
			default: dp_cmd.op = rso_pkg::OP_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/rso_datapath.sv =====
// Datapath of the random shape oscillator: state, shared multiplier, shaping math.
module rso_datapath #(
	parameter int STEP_SIZE = rso_pkg::STEP_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rso_pkg::dp_cmd_t   dp_cmd,
	output rso_pkg::dp_stat_t  stat,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               cmd,
	input  logic signed [23:0] frequency,
	input  logic [16:0]        crossfade,
	input  logic [15:0]        exponent,
	input  logic [15:0]        phase_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] sample
);

	localparam int L = $clog2(STEP_SIZE);
	localparam int PH_W = L + 16;
	localparam int SH = 31 + L;
	localparam logic [63:0] CYC64 = 64'(STEP_SIZE) << 16;
	localparam logic [PH_W:0] CYC_W = CYC64[PH_W:0];
	localparam logic [PH_W:0] CYCM1 = CYC_W - 1'b1;
	localparam logic [PH_W:0] STEP_W = (PH_W + 1)'(STEP_SIZE);
	localparam logic [63:0] RSTEP64 = (64'd1 << SH) / 64'(STEP_SIZE);
	localparam logic [31:0] RSTEP = RSTEP64[31:0];

	// Control state
	logic [23:0]     step_per_hz_q;
	logic [31:0]     lcg_q;
	logic [PH_W-1:0] phase_q;
	logic [15:0]     newer_q, older_q;
	logic            out_valid_q;

	// Working registers
	logic [63:0] prod_q;
	logic signed [23:0] freq_q;
	logic [16:0] xf_q;
	logic [15:0] ex_q, noise_q, p16_q, frac_q;
	logic [16:0] q_q, h16_q, blend_q, pw_q;
	logic signed [18:0] offset_q;
	logic [31:0] y_q, acc_q, c_q, m_q;
	logic [34:0] bacc_q;
	logic [4:0]  k_q;
	logic [20:0] lg_q;
	logic [11:0] ip_q;
	logic [29:0] z_q, n_q;
	logic signed [17:0] sample_q;

	// Combinational helpers
	logic        rising;
	logic [17:0] theta;
	logic [16:0] v, tri_w, xf_inv;
	logic [PH_W:0] rem;
	logic [15:0] p16_d;
	logic [4:0]  k_d;
	logic [31:0] m0;
	logic [33:0] mm;
	logic        sq_ge;
	logic [31:0] qd;
	logic [35:0] qi, rdiv;
	logic [31:0] qf;
	logic [17:0] pw2;
	logic        wneg;
	logic [16:0] wmag;
	logic signed [34:0] sval, rnd, res_w;
	logic [15:0] scale;
	logic signed [18:0] bip_a, bip_b, abs_a, abs_b, maxabs, maxs, scl, off;
	logic [23:0] absf;
	logic [35:0] magfull;
	logic [PH_W-1:0] mag;
	logic [PH_W:0] fsum;
	logic [31:0] mul_a, mul_b;

	assign rising = newer_q > older_q;

	// Cosine argument folded into one half turn
	always_comb begin
		theta = {2'b00, p16_q} + (rising ? 18'd65536 : 18'd0);
		v = (theta <= 18'd65536) ? theta[16:0] : 17'(18'd131072 - theta);
		tri_w = rising ? {1'b0, p16_q} : 17'(17'd65536 - {1'b0, p16_q});
		xf_inv = 17'(17'd65536 - xf_q);
	end

	// Phase to step index, one correction after the reciprocal multiply
	always_comb begin
		rem = {1'b0, phase_q} - ((PH_W + 1)'(q_q) * STEP_W);
		p16_d = 16'(q_q + ((rem >= STEP_W) ? 17'd1 : 17'd0));
	end

	// Leading one of the blend, normalized mantissa
	always_comb begin
		k_d = '0;
		for (int j = 0; j < 17; j++) begin
			if (blend_q[j]) k_d = 5'(j);
		end
		m0 = {15'b0, blend_q} << (5'd30 - k_d);
	end

	// Log squaring step
	always_comb begin
		mm = prod_q[63:30];
		sq_ge = mm >= 34'h0_8000_0000;
	end

	// Quotient by the series index: reciprocal estimate plus one fixup
	always_comb begin
		qd = prod_q[63:32];
		qi = 36'(qd) * 36'(dp_cmd.idx);
		rdiv = 36'(n_q) - qi;
		qf = qd + ((rdiv >= 36'(dp_cmd.idx)) ? 32'd1 : 32'd0);
	end

	// Level offset and the signed output product
	always_comb begin
		scale = rising ? 16'(newer_q - older_q) : 16'(older_q - newer_q);
		bip_a = $signed({2'b00, newer_q, 1'b0}) - 19'sd65536;
		bip_b = $signed({2'b00, older_q, 1'b0}) - 19'sd65536;
		abs_a = (bip_a < 0) ? -bip_a : bip_a;
		abs_b = (bip_b < 0) ? -bip_b : bip_b;
		maxabs = (abs_b > abs_a) ? abs_b : abs_a;
		maxs = (bip_a > bip_b) ? bip_a : bip_b;
		scl = $signed({3'b000, scale});
		off = (maxs > scl) ? (maxabs - scl) : (scl - maxabs);

		pw2 = {pw_q, 1'b0};
		wneg = pw_q < 17'd32768;
		wmag = wneg ? 17'(18'd65536 - pw2) : 17'(pw2 - 18'd65536);
		sval = wneg ? -$signed({2'b00, prod_q[32:0]}) : $signed({2'b00, prod_q[32:0]});
		rnd = (sval + 35'sd32768) >>> 16;
		res_w = rnd + {{16{offset_q[18]}}, offset_q};
	end

	// Phase increment, saturated one step below a cycle
	always_comb begin
		absf = freq_q[23] ? 24'(-freq_q) : 24'(freq_q);
		magfull = prod_q[47:12];
		mag = (magfull > 36'(CYCM1)) ? CYCM1[PH_W-1:0] : magfull[PH_W-1:0];
		fsum = {1'b0, phase_q} + {1'b0, mag};
	end

	// Shared multiplier operand select
	always_comb begin
		case (dp_cmd.op)
			rso_pkg::OP_DIV: begin mul_a = 32'(phase_q); mul_b = RSTEP; end
			rso_pkg::OP_LCG: begin mul_a = lcg_q; mul_b = rso_pkg::LCG_MUL; end
			rso_pkg::OP_X: begin mul_a = 32'(v); mul_b = rso_pkg::PI_Q30; end
			rso_pkg::OP_XX: begin mul_a = prod_q[48:17]; mul_b = prod_q[48:17]; end
			rso_pkg::OP_CMUL: begin mul_a = y_q; mul_b = acc_q; end
			rso_pkg::OP_CC: begin mul_a = c_q; mul_b = c_q; end
			rso_pkg::OP_B1: begin mul_a = 32'(h16_q); mul_b = 32'(xf_inv); end
			rso_pkg::OP_B2: begin mul_a = 32'(tri_w); mul_b = 32'(xf_q); end
			rso_pkg::OP_SQ: begin mul_a = m_q; mul_b = m_q; end
			rso_pkg::OP_T: begin mul_a = 32'(ex_q); mul_b = 32'(lg_q); end
			rso_pkg::OP_TW: begin mul_a = 32'(prod_q[23:0]); mul_b = rso_pkg::LN2_Q30; end
			rso_pkg::OP_E1: begin mul_a = 32'(z_q); mul_b = acc_q; end
			rso_pkg::OP_E2: begin
				mul_a = 32'(prod_q[59:30]);
				mul_b = rso_pkg::div_recip(dp_cmd.idx);
			end
			rso_pkg::OP_O1: begin mul_a = 32'(wmag); mul_b = 32'(scale); end
			rso_pkg::OP_O2: begin mul_a = 32'(absf); mul_b = 32'(step_per_hz_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// Oscillator state, configuration and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_per_hz_q <= rso_pkg::STEP_PER_HZ_RST;
			lcg_q <= rso_pkg::NOISE_SEED_RST;
			phase_q <= '0;
			newer_q <= '0;
			older_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == rso_pkg::CFG_STEP_PER_HZ) begin
					step_per_hz_q <= cfg_data[23:0];
				end else begin
					lcg_q <= cfg_data;
				end
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (dp_cmd.op)
				rso_pkg::OP_TAKE: begin
					if (cmd) phase_q <= PH_W'((PH_W + 1)'(phase_value) * STEP_W);
				end
				rso_pkg::OP_P16: lcg_q <= prod_q[31:0] + rso_pkg::LCG_ADD;
				rso_pkg::OP_O2: if (!stat.out_stall) out_valid_q <= 1'b1;
				rso_pkg::OP_PH: begin
					if (!freq_q[23]) begin
						if (fsum >= CYC_W) begin
							phase_q <= PH_W'(fsum - CYC_W);
							older_q <= newer_q;
							newer_q <= noise_q;
						end else begin
							phase_q <= fsum[PH_W-1:0];
						end
					end else if (mag > phase_q) begin
						phase_q <= PH_W'({1'b0, phase_q} + CYC_W - {1'b0, mag});
					end else begin
						phase_q <= phase_q - mag;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			rso_pkg::OP_TAKE: begin
				freq_q <= frequency;
				xf_q <= (crossfade > 17'd65536) ? 17'd65536 : crossfade;
				ex_q <= exponent;
				noise_q <= lcg_q[30:15];
			end
			rso_pkg::OP_LCG: q_q <= 17'(prod_q >> SH);
			rso_pkg::OP_P16: begin
				p16_q <= p16_d;
				offset_q <= off;
			end
			rso_pkg::OP_YW: begin
				y_q <= prod_q[61:30];
				acc_q <= rso_pkg::COS_SEED;
			end
			rso_pkg::OP_CACC: acc_q <= rso_pkg::cos_coef(dp_cmd.idx) - prod_q[61:30];
			rso_pkg::OP_CD: begin
				c_q <= (prod_q[63:30] >= 34'(rso_pkg::Q30_ONE)) ? 32'd0
					: rso_pkg::Q30_ONE - prod_q[61:30];
			end
			rso_pkg::OP_H: h16_q <= 17'((prod_q[63:30] + 34'd8192) >> 14);
			rso_pkg::OP_B2: bacc_q <= prod_q[34:0];
			rso_pkg::OP_B3: blend_q <= 17'((36'(bacc_q) + 36'(prod_q[34:0]) + 36'd32768) >> 16);
			rso_pkg::OP_PW0: begin
				k_q <= k_d;
				m_q <= m0;
				frac_q <= '0;
				if (blend_q == '0) pw_q <= (ex_q == '0) ? 17'd65536 : 17'd0;
			end
			rso_pkg::OP_SQW: begin
				frac_q <= {frac_q[14:0], sq_ge};
				m_q <= sq_ge ? mm[32:1] : mm[31:0];
			end
			rso_pkg::OP_LG: lg_q <= 21'h10_0000 - {k_q, frac_q};
			rso_pkg::OP_TW: begin
				ip_q <= prod_q[35:24];
				if (stat.ip_big) pw_q <= '0;
			end
			rso_pkg::OP_Z: begin
				z_q <= prod_q[53:24];
				acc_q <= rso_pkg::Q30_ONE;
			end
			rso_pkg::OP_E2: n_q <= prod_q[59:30];
			rso_pkg::OP_E3: acc_q <= rso_pkg::Q30_ONE - qf;
			rso_pkg::OP_PWR: pw_q <= 17'(((acc_q >> ip_q) + 32'd8192) >> 14);
			rso_pkg::OP_O2: if (!stat.out_stall) sample_q <= res_w[17:0];
			default: ;
		endcase
	end

	// Status to the controller
	always_comb begin
		stat.blend_zero = (blend_q == '0);
		stat.ip_big = prod_q[35:24] > 12'd16;
		stat.out_stall = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign sample = sample_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the random shape oscillator with a built-in sample predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned RUN_LIMIT = 3000000;
	localparam int unsigned DRAIN_WAIT = 120;
	localparam logic [63:0] CYCLE = 64'(rso_pkg::STEP_SIZE_DEF) * 64'd65536;
	localparam logic [63:0] Q1 = 64'(rso_pkg::Q30_ONE);

	// Request opcodes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_PHASE = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_index = rso_pkg::CFG_STEP_PER_HZ;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_TICK;
	logic signed [23:0] frequency = '0;
	logic [16:0] crossfade = '0;
	logic [15:0] exponent = '0;
	logic [15:0] phase_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [17:0] sample;

	random_shape_oscillator u_dut (.*);

	// Predictor state
	logic [23:0] m_step_per_hz = rso_pkg::STEP_PER_HZ_RST;
	logic [63:0] m_phase = '0;
	logic [15:0] m_newer = '0;
	logic [15:0] m_older = '0;
	logic [31:0] m_lcg = rso_pkg::NOISE_SEED_RST;

	logic [17:0] sample_q[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_cnt = 0;
	int unsigned cyc_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned n_ticks = 0;
	int unsigned n_sets = 0;
	int unsigned n_checked = 0;
	int unsigned n_cfg = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt > RUN_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			out_ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// cos(pi * v / 2^17) in Q.30
	function automatic logic [63:0] cos_q30(input logic [63:0] v);
		logic [63:0] x, y, acc, d;
		x = (v * 64'(rso_pkg::PI_Q30)) >> 17;
		y = (x * x) >> 30;
		acc = 64'd296;
		acc = 64'd26631 - ((y * acc) >> 30);
		acc = 64'd1491308 - ((y * acc) >> 30);
		acc = 64'd44739243 - ((y * acc) >> 30);
		acc = 64'd536870912 - ((y * acc) >> 30);
		d = (y * acc) >> 30;
		return (d >= Q1) ? 64'd0 : Q1 - d;
	endfunction

	// base^(e/256) via log2 by squaring and an exp2 series
	function automatic logic [63:0] pow_q16(input logic [63:0] base, input logic [63:0] e);
		logic [63:0] m, lg, t, z, acc, k, frac, ip;
		if (base == 0) return (e == 0) ? 64'd65536 : 64'd0;
		k = 0;
		while (k < 16 && (base >> (k + 1)) != 0) k++;
		m = base << (30 - k);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 2 * Q1) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		lg = (64'd16 << 16) - ((k << 16) | frac);
		t = e * lg;
		ip = t >> 24;
		if (ip > 16) return 64'd0;
		z = ((t & 64'hFF_FFFF) * 64'(rso_pkg::LN2_Q30)) >> 24;
		acc = Q1;
		for (int i = 10; i >= 1; i--) acc = Q1 - ((z * acc) >> 30) / 64'(i);
		return ((acc >> ip) + 64'd8192) >> 14;
	endfunction

	// Advance the predictor by one sample tick and return the expected output
	function automatic logic [17:0] next_sample(input logic signed [23:0] f,
			input logic [16:0] xf_in, input logic [15:0] ex);
		longint a, b, scale, bip_a, bip_b, maxabs, offset, maxs, w, res, fr;
		logic [63:0] xf, p16, theta, v, c, h16, tri_v, blend, pw, mag;
		logic [15:0] noise;
		logic rising;
		noise = 16'((m_lcg & 32'h7fff_ffff) >> 15);
		m_lcg = m_lcg * rso_pkg::LCG_MUL + rso_pkg::LCG_ADD;
		fr = longint'(f);
		xf = (xf_in > 17'd65536) ? 64'd65536 : 64'(xf_in);
		a = longint'(m_newer);
		b = longint'(m_older);
		rising = a > b;
		p16 = (m_phase / rso_pkg::STEP_SIZE_DEF) & 64'hFFFF;
		theta = p16 + (rising ? 64'd65536 : 64'd0);
		v = (theta <= 65536) ? theta : 64'd131072 - theta;
		c = cos_q30(v);
		h16 = (((c * c) >> 30) + 64'd8192) >> 14;
		tri_v = rising ? p16 : 64'd65536 - p16;
		blend = (h16 * (64'd65536 - xf) + tri_v * xf + 64'd32768) >> 16;
		pw = pow_q16(blend, 64'(ex));
		scale = (a > b) ? a - b : b - a;
		bip_a = 2 * a - 65536;
		bip_b = 2 * b - 65536;
		maxabs = (bip_a < 0) ? -bip_a : bip_a;
		if (((bip_b < 0) ? -bip_b : bip_b) > maxabs) maxabs = (bip_b < 0) ? -bip_b : bip_b;
		offset = maxabs - scale;
		maxs = (bip_a > bip_b) ? bip_a : bip_b;
		if (!(maxs > scale)) offset = -offset;
		w = 2 * longint'(pw) - 65536;
		res = ((w * scale + 32768) >>> 16) + offset;
		// phase advance with saturated increment
		mag = (64'((fr < 0) ? -fr : fr) * 64'(m_step_per_hz)) >> 12;
		if (mag > CYCLE - 1) mag = CYCLE - 1;
		if (fr >= 0) begin
			m_phase = m_phase + mag;
			if (m_phase >= CYCLE) begin
				m_phase = m_phase - CYCLE;
				m_older = m_newer;
				m_newer = noise;
			end
		end else if (mag > m_phase) begin
			m_phase = m_phase + CYCLE - mag;
		end else begin
			m_phase = m_phase - mag;
		end
		return res[17:0];
	endfunction

	// Result checker
	always @(posedge clk) begin
		logic [17:0] want;
		if (out_valid && out_ready) begin
			if (sample_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10) $display("unexpected sample %0d", sample);
			end else begin
				want = sample_q.pop_front();
				n_checked++;
				if (sample !== want) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("sample mismatch: expected %0d got %0d",
							$signed(want), sample);
				end
			end
		end
	end

	// Send one request and predict its outcome at acceptance
	task automatic send_req(input logic c, input logic signed [23:0] f,
			input logic [16:0] xf, input logic [15:0] ex, input logic [15:0] ph);
		in_valid <= 1'b1;
		cmd <= c;
		frequency <= f;
		crossfade <= xf;
		exponent <= ex;
		phase_value <= ph;
		do @(posedge clk); while (!in_ready);
		if (c == CMD_PHASE) begin
			m_phase = 64'(ph) * rso_pkg::STEP_SIZE_DEF;
			n_sets++;
		end else begin
			sample_q.push_back(next_sample(f, xf, ex));
			n_ticks++;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Wait until every expected sample is out and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Register write while idle
	task automatic write_reg(input logic idx, input logic [31:0] data);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == rso_pkg::CFG_STEP_PER_HZ) begin
			m_step_per_hz = data[23:0];
		end else begin
			m_lcg = data;
		end
		n_cfg++;
	endtask

	// One random request: mostly ticks, with a spread of magnitudes
	task automatic random_req();
		logic signed [23:0] f;
		logic [16:0] xf;
		logic [15:0] ex;
		case ($urandom_range(3))
			0: f = 24'($urandom);
			1: f = 24'($signed($urandom_range(4000)) - 2000);
			2: f = 24'($urandom_range(200000));
			default: f = 24'($urandom_range(8388607));
		endcase
		xf = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
		ex = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
		if ($urandom_range(11) == 0) send_req(CMD_PHASE, f, xf, ex, 16'($urandom));
		else send_req(CMD_TICK, f, xf, ex, 16'($urandom));
	endtask

	// Directed corners: field extremes, zero blend, saturation, phase sets
	task automatic test_directed();
		send_req(CMD_TICK, 24'sd0, 17'd0, 16'd0, 16'd0);
		send_req(CMD_TICK, 24'sh7FFFFF, 17'd65536, 16'hFFFF, 16'hFFFF);
		send_req(CMD_TICK, 24'sh800000, 17'h1FFFF, 16'd256, 16'd0);
		send_req(CMD_TICK, 24'sd25600, 17'd65537, 16'd512, 16'd0);
		send_req(CMD_PHASE, 24'sd0, 17'd0, 16'd0, 16'd32768);
		send_req(CMD_TICK, 24'sd0, 17'd0, 16'd0, 16'd0);
		send_req(CMD_PHASE, 24'sd0, 17'd0, 16'd0, 16'd32768);
		send_req(CMD_TICK, 24'sd0, 17'd0, 16'd300, 16'd0);
		send_req(CMD_PHASE, 24'sd0, 17'd0, 16'd0, 16'hFFFF);
		send_req(CMD_TICK, 24'sd1000, 17'd32768, 16'd128, 16'd0);
		send_req(CMD_PHASE, 24'sd0, 17'd0, 16'd0, 16'd0);
		send_req(CMD_TICK, -24'sd1, 17'd40000, 16'd1, 16'd0);
		for (int i = 0; i < 8; i++)
			send_req(CMD_TICK, 24'sh7FFFFF, 17'($urandom_range(65536)), 16'($urandom_range(700)),
				16'd0);
		write_reg(rso_pkg::CFG_STEP_PER_HZ, 32'h00FF_FFFF);
		send_req(CMD_TICK, 24'sh7FFFFF, 17'd65536, 16'd256, 16'd0);
		send_req(CMD_TICK, 24'sh800000, 17'd0, 16'd256, 16'd0);
		send_req(CMD_TICK, 24'sh800000, 17'd100, 16'd0, 16'd0);
	endtask

	// Receiver holds off long while the sender keeps offering requests
	task automatic test_backpressure();
		write_reg(rso_pkg::CFG_NOISE_SEED, 32'hFFFF_FFFF);
		send_idle_pct = 0;
		hold_cnt = 2000;
		repeat (8) random_req();
		drain();
	endtask

	// Random traffic under one idling pattern and one register setting
	task automatic test_random(input int unsigned n, input int unsigned s_pct,
			input int unsigned r_pct, input logic [23:0] sph, input logic [31:0] seed);
		write_reg(rso_pkg::CFG_STEP_PER_HZ, 32'(sph));
		write_reg(rso_pkg::CFG_NOISE_SEED, seed);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		repeat (n) random_req();
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(440, 0, 0, 24'd0, 32'd0);
		test_random(440, 83, 0, rso_pkg::STEP_PER_HZ_RST, 32'($urandom));
		test_random(440, 0, 83, 24'($urandom), 32'hFFFF_FFFF);
		test_random(440, 19, 19, 24'h00FF_FFFF, rso_pkg::NOISE_SEED_RST);
		drain();
		$display("covered %0d sample ticks, %0d phase sets, %0d register writes",
			n_ticks, n_sets, n_cfg);
		$display("checked %0d samples under four idle patterns and a long hold-off, %0d errors",
			n_checked, err_cnt);
		if (err_cnt == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
